// ===== hdl/bmra_pkg.sv =====
// Shared types and constants of the sector bitmap run allocator.
// No dependencies; every other file in hdl/ but bmra_ram uses this package.
package bmra_pkg;

   localparam int MAP_WORDS = 1024;
   localparam int MAX_RUN   = 4096;
   localparam int WORD_W    = 32;
   localparam int ADDR_W    = $clog2(MAP_WORDS);
   localparam int USED_W    = ADDR_W + 1;
   localparam int BIT_W     = ADDR_W + 5;
   localparam int END_W     = BIT_W + 1;
   localparam int LEN_W     = 13;
   localparam int FDS_W     = 24;
   localparam int SECTOR_W  = 25;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_RUN_LENGTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WORDS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_SECTOR = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_ALLOC = 2'd1,
      OP_READ  = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NO_FREE   = 2'd1,
      STAT_BLOCKED   = 2'd2,
      STAT_BAD_INDEX = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_EXEC,
      ENG_RDWAIT,
      ENG_SCAN,
      ENG_CHECK,
      ENG_COMMIT,
      ENG_DONE
   } eng_state_type;

   typedef struct packed {
      logic [LEN_W-1:0]  run_length;
      logic [USED_W-1:0] map_words;
      logic [FDS_W-1:0]  first_data;
   } cfg_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [WORD_W-1:0] wr_data;
   } ram_req_type;

   typedef struct packed {
      logic                valid;
      status_type          status;
      logic [SECTOR_W-1:0] first_sector;
      logic [WORD_W-1:0]   read_data;
   } result_type;

endpackage

// ===== hdl/bmra_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bmra_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bmra_engine.sv =====
// Operation sequencer: load, read and first-fit run allocation over the bitmap RAM.
// Depends on bmra_pkg.
module bmra_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  bmra_pkg::cfg_type                 cfg,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_opcode,
   input  logic [bmra_pkg::ADDR_W-1:0]       req_word_index,
   input  logic [bmra_pkg::WORD_W-1:0]       req_word_data,
   output bmra_pkg::ram_req_type             ram_req,
   input  logic [bmra_pkg::WORD_W-1:0]       ram_rd_data,
   output bmra_pkg::result_type              res,
   input  logic                              res_take
);

   // lowest clear bit of a word that is not all ones
   function automatic logic [4:0] first_zero(input logic [bmra_pkg::WORD_W-1:0] v);
      logic [4:0] k;
      k = 5'd0;
      for (int i = bmra_pkg::WORD_W - 1; i >= 0; i--) begin
         if (!v[i]) begin
            k = 5'(i);
         end
      end
      return k;
   endfunction

   bmra_pkg::eng_state_type state_ff, state_in;

   bmra_pkg::opcode_type              op_ff, op_in;
   logic [bmra_pkg::ADDR_W-1:0]       idx_ff, idx_in;
   logic [bmra_pkg::WORD_W-1:0]       wdata_ff, wdata_in;
   logic [bmra_pkg::USED_W-1:0]       cnt_ff, cnt_in;
   logic                              dv_ff, dv_in;
   logic [bmra_pkg::ADDR_W-1:0]       dw_ff, dw_in;
   logic [bmra_pkg::BIT_W-1:0]        start_ff, start_in;
   logic [bmra_pkg::BIT_W-1:0]        end_ff, end_in;
   bmra_pkg::status_type              status_ff, status_in;
   logic [bmra_pkg::SECTOR_W-1:0]     sector_ff, sector_in;
   logic [bmra_pkg::WORD_W-1:0]       rdata_ff, rdata_in;

   logic [bmra_pkg::USED_W-1:0]       used;
   logic [bmra_pkg::LEN_W-1:0]        len;
   logic [bmra_pkg::END_W-1:0]        total;
   logic                              idx_ok;
   logic                              hit;
   logic [bmra_pkg::BIT_W-1:0]        hit_start;
   logic [bmra_pkg::END_W-1:0]        hit_end;
   logic                              run_fits;
   logic                              scan_last;
   logic                              scan_issue;
   logic [bmra_pkg::ADDR_W-1:0]       first_word, last_word;
   logic                              walk_issue;
   logic [4:0]                        lo_bit, hi_bit;
   logic [bmra_pkg::WORD_W-1:0]       run_mask;
   logic                              conflict;
   logic                              walk_last;
   logic [bmra_pkg::SECTOR_W-1:0]     sector_calc;

   // clamped configuration
   assign used  = (cfg.map_words > bmra_pkg::USED_W'(bmra_pkg::MAP_WORDS)) ?
                  bmra_pkg::USED_W'(bmra_pkg::MAP_WORDS) : cfg.map_words;
   assign len   = (cfg.run_length > bmra_pkg::LEN_W'(bmra_pkg::MAX_RUN)) ?
                  bmra_pkg::LEN_W'(bmra_pkg::MAX_RUN) : cfg.run_length;
   assign total = {used, 5'd0};
   assign idx_ok = {1'b0, idx_ff} < used;

   // scan: first word with a clear bit
   assign hit        = dv_ff && (ram_rd_data != '1);
   assign hit_start  = {dw_ff, first_zero(ram_rd_data)};
   assign hit_end    = {1'b0, hit_start} + bmra_pkg::END_W'(len) - bmra_pkg::END_W'(1);
   assign run_fits   = hit_end < total;
   assign scan_last  = dv_ff && ({1'b0, dw_ff} == used - bmra_pkg::USED_W'(1));
   assign scan_issue = cnt_ff < used;

   // walk over the words of the run (check, then commit)
   assign first_word = start_ff[bmra_pkg::BIT_W-1:5];
   assign last_word  = end_ff[bmra_pkg::BIT_W-1:5];
   assign walk_issue = cnt_ff <= {1'b0, last_word};
   assign lo_bit     = (dw_ff == first_word) ? start_ff[4:0] : 5'd0;
   assign hi_bit     = (dw_ff == last_word) ? end_ff[4:0] : 5'd31;
   assign run_mask   = ({bmra_pkg::WORD_W{1'b1}} << lo_bit) &
                       ({bmra_pkg::WORD_W{1'b1}} >> (5'd31 - hi_bit));
   assign conflict   = dv_ff && ((ram_rd_data & run_mask) != '0);
   assign walk_last  = dv_ff && (dw_ff == last_word);
   assign sector_calc = bmra_pkg::SECTOR_W'(start_ff) + bmra_pkg::SECTOR_W'(cfg.first_data)
                        - bmra_pkg::SECTOR_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bmra_pkg::ENG_IDLE: begin
            if (req_valid) begin
               state_in = bmra_pkg::ENG_EXEC;
            end
         end
         bmra_pkg::ENG_EXEC: begin
            case (op_ff)
               bmra_pkg::OP_READ: begin
                  state_in = idx_ok ? bmra_pkg::ENG_RDWAIT : bmra_pkg::ENG_DONE;
               end
               bmra_pkg::OP_ALLOC: begin
                  state_in = (len == '0 || used == '0) ? bmra_pkg::ENG_DONE :
                             bmra_pkg::ENG_SCAN;
               end
               default: begin
                  state_in = bmra_pkg::ENG_DONE;
               end
            endcase
         end
         bmra_pkg::ENG_RDWAIT: begin
            state_in = bmra_pkg::ENG_DONE;
         end
         bmra_pkg::ENG_SCAN: begin
            if (hit) begin
               state_in = run_fits ? bmra_pkg::ENG_CHECK : bmra_pkg::ENG_DONE;
            end else if (scan_last) begin
               state_in = bmra_pkg::ENG_DONE;
            end
         end
         bmra_pkg::ENG_CHECK: begin
            if (conflict) begin
               state_in = bmra_pkg::ENG_DONE;
            end else if (walk_last) begin
               state_in = bmra_pkg::ENG_COMMIT;
            end
         end
         bmra_pkg::ENG_COMMIT: begin
            if (walk_last) begin
               state_in = bmra_pkg::ENG_DONE;
            end
         end
         bmra_pkg::ENG_DONE: begin
            if (res_take) begin
               state_in = bmra_pkg::ENG_IDLE;
            end
         end
         default: begin
            state_in = bmra_pkg::ENG_IDLE;
         end
      endcase
   end

   // outputs: handshake, RAM port, result
   always_comb begin
      req_ready       = 1'b0;
      ram_req.rd_en   = 1'b0;
      ram_req.rd_addr = cnt_ff[bmra_pkg::ADDR_W-1:0];
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = dw_ff;
      ram_req.wr_data = ram_rd_data | run_mask;
      case (state_ff)
         bmra_pkg::ENG_IDLE: begin
            req_ready = 1'b1;
         end
         bmra_pkg::ENG_EXEC: begin
            ram_req.rd_addr = idx_ff;
            ram_req.wr_addr = idx_ff;
            ram_req.wr_data = wdata_ff;
            ram_req.rd_en   = (op_ff == bmra_pkg::OP_READ) && idx_ok;
            ram_req.wr_en   = (op_ff == bmra_pkg::OP_LOAD) && idx_ok;
         end
         bmra_pkg::ENG_SCAN: begin
            ram_req.rd_en = scan_issue;
         end
         bmra_pkg::ENG_CHECK: begin
            ram_req.rd_en = walk_issue;
         end
         bmra_pkg::ENG_COMMIT: begin
            ram_req.rd_en = walk_issue;
            ram_req.wr_en = dv_ff;
         end
         default: begin
         end
      endcase
      res.valid        = (state_ff == bmra_pkg::ENG_DONE);
      res.status       = status_ff;
      res.first_sector = sector_ff;
      res.read_data    = rdata_ff;
   end

   // datapath next values
   always_comb begin
      op_in     = op_ff;
      idx_in    = idx_ff;
      wdata_in  = wdata_ff;
      cnt_in    = cnt_ff;
      dv_in     = 1'b0;
      dw_in     = cnt_ff[bmra_pkg::ADDR_W-1:0];
      start_in  = start_ff;
      end_in    = end_ff;
      status_in = status_ff;
      sector_in = sector_ff;
      rdata_in  = rdata_ff;
      case (state_ff)
         bmra_pkg::ENG_IDLE: begin
            if (req_valid) begin
               op_in    = bmra_pkg::opcode_type'(req_opcode);
               idx_in   = req_word_index;
               wdata_in = req_word_data;
            end
         end
         bmra_pkg::ENG_EXEC: begin
            cnt_in    = '0;
            status_in = bmra_pkg::STAT_OK;
            sector_in = '0;
            rdata_in  = '0;
            case (op_ff)
               bmra_pkg::OP_LOAD,
               bmra_pkg::OP_READ: begin
                  if (!idx_ok) begin
                     status_in = bmra_pkg::STAT_BAD_INDEX;
                  end
               end
               bmra_pkg::OP_ALLOC: begin
                  if (len != '0 && used == '0) begin
                     status_in = bmra_pkg::STAT_NO_FREE;
                  end
               end
               default: begin
               end
            endcase
         end
         bmra_pkg::ENG_RDWAIT: begin
            rdata_in = ram_rd_data;
         end
         bmra_pkg::ENG_SCAN: begin
            dv_in  = scan_issue;
            cnt_in = scan_issue ? cnt_ff + bmra_pkg::USED_W'(1) : cnt_ff;
            if (hit) begin
               // read already in flight is dropped by clearing dv
               dv_in    = 1'b0;
               start_in = hit_start;
               end_in   = hit_end[bmra_pkg::BIT_W-1:0];
               cnt_in   = {1'b0, hit_start[bmra_pkg::BIT_W-1:5]};
               if (!run_fits) begin
                  status_in = bmra_pkg::STAT_BLOCKED;
               end
            end else if (scan_last) begin
               status_in = bmra_pkg::STAT_NO_FREE;
            end
         end
         bmra_pkg::ENG_CHECK: begin
            dv_in  = walk_issue;
            cnt_in = walk_issue ? cnt_ff + bmra_pkg::USED_W'(1) : cnt_ff;
            if (conflict) begin
               status_in = bmra_pkg::STAT_BLOCKED;
            end else if (walk_last) begin
               dv_in  = 1'b0;
               cnt_in = {1'b0, first_word};
            end
         end
         bmra_pkg::ENG_COMMIT: begin
            dv_in  = walk_issue;
            cnt_in = walk_issue ? cnt_ff + bmra_pkg::USED_W'(1) : cnt_ff;
            if (walk_last) begin
               sector_in = sector_calc;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmra_pkg::ENG_IDLE;
         dv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         dv_ff    <= dv_in;
      end
      op_ff     <= op_in;
      idx_ff    <= idx_in;
      wdata_ff  <= wdata_in;
      cnt_ff    <= cnt_in;
      dw_ff     <= dw_in;
      start_ff  <= start_in;
      end_ff    <= end_in;
      status_ff <= status_in;
      sector_ff <= sector_in;
      rdata_ff  <= rdata_in;
   end

endmodule

// ===== hdl/bmra_out.sv =====
// Result output register: holds one finished item for the rsp_ channel.
// Depends on bmra_pkg.
module bmra_out (
   input  logic                              clock,
   input  logic                              reset,
   input  bmra_pkg::result_type              res,
   output logic                              res_take,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [bmra_pkg::SECTOR_W-1:0]     rsp_first_sector,
   output logic [bmra_pkg::WORD_W-1:0]       rsp_read_data
);

   logic                          full_ff, full_in;
   logic [1:0]                    status_ff, status_in;
   logic [bmra_pkg::SECTOR_W-1:0] sector_ff, sector_in;
   logic [bmra_pkg::WORD_W-1:0]   rdata_ff, rdata_in;

   // load when empty or when the held item leaves this cycle
   assign res_take = res.valid && (!full_ff || rsp_ready);

   always_comb begin
      full_in   = full_ff;
      status_in = status_ff;
      sector_in = sector_ff;
      rdata_in  = rdata_ff;
      if (res_take) begin
         full_in   = 1'b1;
         status_in = res.status;
         sector_in = res.first_sector;
         rdata_in  = res.read_data;
      end else if (rsp_ready) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
      status_ff <= status_in;
      sector_ff <= sector_in;
      rdata_ff  <= rdata_in;
   end

   assign rsp_valid        = full_ff;
   assign rsp_status       = status_ff;
   assign rsp_first_sector = sector_ff;
   assign rsp_read_data    = rdata_ff;

endmodule

// ===== hdl/sector_bitmap_run_allocator_core.sv =====
// Top level of the sector bitmap run allocator: CSRs, bitmap RAM, sequencer, output register.
// Depends on bmra_pkg, bmra_ram, bmra_engine and bmra_out.
//
// The block keeps a 1024 x 32-bit sector bitmap (bit n of word w is map bit w*32+n, set means
// in use) in one synchronous RAM. Software loads words before use; the RAM has no reset and a
// word that was never loaded reads as garbage, so there is no clearing pass after reset. Items
// are handled one at a time. A load or an unused opcode goes through the execute and done
// states to a result in the output register; a read has a read-wait state between them. An
// allocate scans the words in use at one RAM read per cycle up to the first word with a clear
// bit, then it walks the words the run touches twice, once to check that they are clear and
// once to set them (read-modify-write); the single read port of the bitmap RAM sets the pace.
// The output register holds a finished result while the next item is accepted.
// CSRs are to be written only while the block is idle; the block itself does not enforce it.
module sector_bitmap_run_allocator_core (
   input  logic                              clock,
   input  logic                              reset,
   // request item channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_opcode,
   input  logic [bmra_pkg::ADDR_W-1:0]       req_word_index,
   input  logic [bmra_pkg::WORD_W-1:0]       req_word_data,
   // response item channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [bmra_pkg::SECTOR_W-1:0]     rsp_first_sector,
   output logic [bmra_pkg::WORD_W-1:0]       rsp_read_data,
   // CSR write port
   input  logic                              csr_write_enable,
   input  logic [bmra_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bmra_pkg::CSR_W-1:0]        csr_write_data
);

   bmra_pkg::cfg_type      cfg_ff, cfg_in;
   bmra_pkg::ram_req_type  ram_req;
   logic [bmra_pkg::WORD_W-1:0] ram_rd_data;
   bmra_pkg::result_type   res;
   logic                   res_take;

   // CSRs; unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            bmra_pkg::CSR_RUN_LENGTH: begin
               cfg_in.run_length = csr_write_data[bmra_pkg::LEN_W-1:0];
            end
            bmra_pkg::CSR_MAP_WORDS: begin
               cfg_in.map_words = csr_write_data[bmra_pkg::USED_W-1:0];
            end
            bmra_pkg::CSR_FIRST_SECTOR: begin
               cfg_in.first_data = csr_write_data[bmra_pkg::FDS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.run_length <= bmra_pkg::LEN_W'(2048);
         cfg_ff.map_words  <= bmra_pkg::USED_W'(1024);
         cfg_ff.first_data <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // bitmap store; the sequencer never reads and writes one word in the same cycle
   bmra_ram #(
      .WIDTH (bmra_pkg::WORD_W),
      .DEPTH (bmra_pkg::MAP_WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   bmra_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_word_index (req_word_index),
      .req_word_data  (req_word_data),
      .ram_req        (ram_req),
      .ram_rd_data    (ram_rd_data),
      .res            (res),
      .res_take       (res_take)
   );

   bmra_out u_out (
      .clock            (clock),
      .reset            (reset),
      .res              (res),
      .res_take         (res_take),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_first_sector (rsp_first_sector),
      .rsp_read_data    (rsp_read_data)
   );

   // one item in flight: an accept takes the sequencer out of idle
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while previous item still in progress");

   // bitmap writes stay inside the words in use
   a_wr_in_map: assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en |-> ({1'b0, ram_req.wr_addr} < cfg_ff.map_words))
      else $error("bitmap write outside words in use");

   // read-modify-write never overlaps a read of the same word
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (ram_req.wr_en && ram_req.rd_en) |-> (ram_req.wr_addr != ram_req.rd_addr))
      else $error("bitmap read and write to the same word");

   // a rejected index returns no data and no sector
   a_bad_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bmra_pkg::STAT_BAD_INDEX) |->
      (rsp_first_sector == '0 && rsp_read_data == '0))
      else $error("bad index result carries data");

endmodule

// ===== dv/sector_bitmap_run_allocator_core_tb.sv =====
// Self-checking testbench for sector_bitmap_run_allocator_core: stimulus, bitmap predictor
// and reply checker in one file. Depends on bmra_pkg and the core RTL in hdl/.
`timescale 1ns / 100ps

// Tracks the expected bitmap, the CSR settings and the replies still owed by the block.
class bitmap_scoreboard;
   typedef logic [bmra_pkg::SECTOR_W-1:0] sector_type;
   typedef struct {
      bmra_pkg::status_type    status;
      sector_type              first_sector;
      logic [bmra_pkg::WORD_W-1:0] read_data;
   } reply_type;

   logic [31:0] sector_map [bmra_pkg::MAP_WORDS];
   bit          loaded     [bmra_pkg::MAP_WORDS];
   logic [12:0] run_length;
   logic [10:0] map_words;
   logic [23:0] first_data;
   reply_type   owed_replies [$];
   int          errors;

   function new();
      foreach (sector_map[w]) begin
         sector_map[w] = '0;
         loaded[w] = 1'b0;
      end
      run_length = 13'd2048;
      map_words  = 11'd1024;
      first_data = '0;
      errors     = 0;
   endfunction

   function void set_register(logic [1:0] index, logic [23:0] value);
      case (index)
         bmra_pkg::CSR_RUN_LENGTH:   run_length = value[12:0];
         bmra_pkg::CSR_MAP_WORDS:    map_words  = value[10:0];
         bmra_pkg::CSR_FIRST_SECTOR: first_data = value;
         default: ;
      endcase
   endfunction

   function int words_used();
      return (map_words > bmra_pkg::MAP_WORDS) ? bmra_pkg::MAP_WORDS : int'(map_words);
   endfunction

   function int run_bits();
      return (run_length > bmra_pkg::MAX_RUN) ? bmra_pkg::MAX_RUN : int'(run_length);
   endfunction

   // lowest clear map bit among the words in use, -1 if the map is full
   function int first_clear_bit();
      for (int w = 0; w < words_used(); w++) begin
         if (sector_map[w] != 32'hFFFF_FFFF) begin
            for (int k = 0; k < 32; k++) begin
               if (!sector_map[w][k]) return w * 32 + k;
            end
         end
      end
      return -1;
   endfunction

   // True when an allocate now would only touch loaded words (plus one word of slack
   // past the run, in case the engine fetches ahead).
   function bit scan_is_safe();
      int start;
      int len;
      int last_word;
      start = first_clear_bit();
      len = (run_bits() > 0) ? run_bits() : 1;
      if (start < 0) last_word = words_used() - 1;
      else last_word = (start + len - 1) / 32 + 1;
      if (last_word > words_used() - 1) last_word = words_used() - 1;
      for (int w = 0; w <= last_word; w++) begin
         if (!loaded[w]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function reply_type compute_reply(logic [1:0] op, logic [9:0] idx, logic [31:0] data);
      reply_type r;
      int start;
      int len;
      int total;
      bit blocked;
      r.status = bmra_pkg::STAT_OK;
      r.first_sector = '0;
      r.read_data = '0;
      case (op)
         bmra_pkg::OP_LOAD, bmra_pkg::OP_READ: begin
            if (int'(idx) >= words_used()) begin
               r.status = bmra_pkg::STAT_BAD_INDEX;
            end else if (op == bmra_pkg::OP_LOAD) begin
               sector_map[idx] = data;
               loaded[idx] = 1'b1;
            end else begin
               r.read_data = sector_map[idx];
            end
         end
         bmra_pkg::OP_ALLOC: begin
            len = run_bits();
            if (len != 0) begin
               start = first_clear_bit();
               if (start < 0) begin
                  r.status = bmra_pkg::STAT_NO_FREE;
               end else begin
                  total = words_used() * 32;
                  blocked = 1'b0;
                  for (int b = start; b < start + len; b++) begin
                     if (b >= total) blocked = 1'b1;
                     else if (sector_map[b / 32][b % 32]) blocked = 1'b1;
                  end
                  if (blocked) begin
                     r.status = bmra_pkg::STAT_BLOCKED;
                  end else begin
                     for (int b = start; b < start + len; b++) sector_map[b / 32][b % 32] = 1'b1;
                     r.first_sector = sector_type'(start) + sector_type'(first_data) - 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function void note_request(logic [1:0] op, logic [9:0] idx, logic [31:0] data);
      owed_replies.push_back(compute_reply(op, idx, data));
   endfunction

   function int pending();
      return owed_replies.size();
   endfunction

   task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got 0x%0h want 0x%0h", what, got, want);
   endtask

   task check_reply(logic [1:0] status, sector_type sector, logic [31:0] rd);
      reply_type want;
      if (owed_replies.size() == 0) begin
         report_mismatch("unexpected reply, status", status, 0);
      end else begin
         want = owed_replies.pop_front();
         if (status !== want.status) report_mismatch("status", status, want.status);
         if (sector !== want.first_sector)
            report_mismatch("first_sector", sector, want.first_sector);
         if (rd !== want.read_data) report_mismatch("read_data", rd, want.read_data);
      end
   endtask
endclass

module sector_bitmap_run_allocator_core_tb;

   // opcode 3 has no enum member in the package; it must be a no-op
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // cycles with no handshake on either side before the run is declared hung
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_CYCLES = 80;
   localparam int ITEM_GOAL = 290;
   // from this many items on, neither side inserts bubbles
   localparam int CALM_AFTER = 250;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [1:0]                    req_opcode = OP_UNUSED;
   logic [bmra_pkg::ADDR_W-1:0]   req_word_index = '0;
   logic [bmra_pkg::WORD_W-1:0]   req_word_data = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [1:0]                    rsp_status;
   logic [bmra_pkg::SECTOR_W-1:0] rsp_first_sector;
   logic [bmra_pkg::WORD_W-1:0]   rsp_read_data;
   logic                          csr_write_enable = 1'b0;
   logic [bmra_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [bmra_pkg::CSR_W-1:0]    csr_write_data = '0;

   bitmap_scoreboard sb = new();

   int items_sent = 0;
   bit calm_tail = 1'b0;     // last part of the run: no idling anywhere
   bit steady = 1'b0;        // per phase: sender never pauses
   bit hold_request = 1'b0;  // asks the receiver for one long hold-off

   always #10 clock = ~clock;

   sector_bitmap_run_allocator_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_word_index   (req_word_index),
      .req_word_data    (req_word_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_first_sector (rsp_first_sector),
      .rsp_read_data    (rsp_read_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Bitmap word values: mostly empty or full words so that allocations both succeed
   // and get blocked, plus random, low-ones and single-hole shapes.
   function automatic logic [31:0] bitmap_pattern();
      int sel;
      int k;
      sel = $urandom_range(0, 9);
      k = $urandom_range(1, 31);
      case (sel)
         0, 1, 2, 3: return 32'h0;
         4, 5:       return 32'hFFFF_FFFF;
         6:          return $urandom;
         7:          return (32'h1 << k) - 1;
         8:          return ~(32'h1 << k);
         default:    return $urandom & $urandom;
      endcase
   endfunction

   // Offer one item; valid holds until accepted. A bubble may follow.
   task automatic send_item(logic [1:0] op, logic [9:0] idx, logic [31:0] data);
      req_opcode     <= op;
      req_word_index <= idx;
      req_word_data  <= data;
      req_valid      <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(op, idx, data);
      items_sent++;
      if (items_sent >= CALM_AFTER) calm_tail = 1'b1;
      if (!calm_tail && !steady && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // Drop valid and drain: every reply in, then a few cycles so the engine is idle.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(logic [23:0] run, logic [23:0] used, logic [23:0] fds);
      settle();
      csr_write_enable <= 1'b1;
      csr_index        <= bmra_pkg::CSR_RUN_LENGTH;
      csr_write_data   <= run;
      sb.set_register(bmra_pkg::CSR_RUN_LENGTH, run);
      @(posedge clock);
      csr_index        <= bmra_pkg::CSR_MAP_WORDS;
      csr_write_data   <= used;
      sb.set_register(bmra_pkg::CSR_MAP_WORDS, used);
      @(posedge clock);
      csr_index        <= bmra_pkg::CSR_FIRST_SECTOR;
      csr_write_data   <= fds;
      sb.set_register(bmra_pkg::CSR_FIRST_SECTOR, fds);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // One random item. Allocations are only issued when the scan stays on loaded words;
   // reads only hit loaded words or indexes outside the map.
   task automatic random_item();
      int used;
      int pick;
      int prefix;
      logic [9:0] idx;
      used = sb.words_used();
      prefix = (used > 32) ? 32 : used;
      pick = $urandom_range(0, 99);
      if (pick < 35 && sb.scan_is_safe()) begin
         send_item(bmra_pkg::OP_ALLOC, 10'($urandom), $urandom);
      end else if (pick < 60 && used > 0) begin
         send_item(bmra_pkg::OP_LOAD, 10'($urandom_range(0, used - 1)), bitmap_pattern());
      end else if (pick < 75 && used > 0) begin
         idx = 10'($urandom_range(0, used - 1));
         if (!sb.loaded[idx]) idx = 10'($urandom_range(0, prefix - 1));
         send_item(bmra_pkg::OP_READ, idx, $urandom);
      end else if (pick < 88 && used < bmra_pkg::MAP_WORDS) begin
         // index past the words in use
         idx = 10'($urandom_range(used, bmra_pkg::MAP_WORDS - 1));
         send_item($urandom_range(0, 1) ? bmra_pkg::OP_LOAD : bmra_pkg::OP_READ, idx,
                   $urandom);
      end else begin
         send_item(OP_UNUSED, 10'($urandom), $urandom);
      end
   endtask

   // New settings, then load the low words in use (at most 32), then random traffic.
   task automatic run_phase(int run, int used, logic [23:0] fds, int count, bit squeeze);
      int prefix;
      apply_settings(24'(run), 24'(used), fds);
      steady = ($urandom_range(0, 3) == 0);
      if (squeeze) hold_request = 1'b1;
      prefix = sb.words_used();
      if (prefix > 32) prefix = 32;
      for (int w = 0; w < prefix; w++) send_item(bmra_pkg::OP_LOAD, 10'(w), bitmap_pattern());
      repeat (count) random_item();
   endtask

   function automatic int pick_run();
      int sel;
      sel = $urandom_range(0, 7);
      if (sel < 6) return $urandom_range(1, 24);
      if (sel == 6) return $urandom_range(25, 200);
      return $urandom_range(0, 8191);
   endfunction

   // Receiver: checks every accepted reply, stalls in short random bursts, and once
   // holds off for HOLD_CYCLES so the block backs up into its input.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) sb.check_reply(rsp_status, rsp_first_sector, rsp_read_data);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: a long stretch with no handshake on either channel means a hang.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Small map of 4 words, 8-bit runs, no sector offset.
      apply_settings(24'd8, 24'd4, 24'd0);
      send_item(OP_UNUSED, 10'h3FF, 32'hFFFF_FFFF);    // unused opcode: plain OK
      send_item(bmra_pkg::OP_LOAD, 10'd0, 32'h0000_0000);
      send_item(bmra_pkg::OP_LOAD, 10'd1, 32'hFFFF_FFFF);
      send_item(bmra_pkg::OP_LOAD, 10'd2, 32'h0000_FF00);
      send_item(bmra_pkg::OP_LOAD, 10'd3, 32'h7FFF_FFFF);
      send_item(bmra_pkg::OP_ALLOC, 10'd0, 32'd0);     // bit 0, offset 0: wraps to all ones
      send_item(bmra_pkg::OP_READ, 10'd0, 32'd0);
      send_item(bmra_pkg::OP_LOAD, 10'd0, 32'hFFFF_FFF0);
      send_item(bmra_pkg::OP_ALLOC, 10'd0, 32'd0);     // run hits a set bit
      send_item(bmra_pkg::OP_READ, 10'd0, 32'd0);      // map untouched by the blocked run
      send_item(bmra_pkg::OP_LOAD, 10'd0, 32'hFFFF_FFFF);
      send_item(bmra_pkg::OP_ALLOC, 10'd0, 32'd0);     // first fit skips two words
      send_item(bmra_pkg::OP_ALLOC, 10'd0, 32'd0);
      send_item(bmra_pkg::OP_LOAD, 10'd2, 32'hFFFF_FFFF);
      send_item(bmra_pkg::OP_ALLOC, 10'd0, 32'd0);     // run passes the last bit in use
      send_item(bmra_pkg::OP_LOAD, 10'd3, 32'hFFFF_FFFF);
      send_item(bmra_pkg::OP_ALLOC, 10'd0, 32'd0);     // map full
      send_item(bmra_pkg::OP_READ, 10'd3, 32'd0);
      send_item(bmra_pkg::OP_READ, 10'h3FF, 32'd0);    // index out of use
      send_item(bmra_pkg::OP_LOAD, 10'd4, 32'hA5A5_5A5A);
      send_item(bmra_pkg::OP_READ, 10'h200, 32'd0);

      // zero run length: OK with nothing reserved
      apply_settings(24'd0, 24'd4, 24'hFF_FFFF);
      send_item(bmra_pkg::OP_LOAD, 10'd3, 32'h0);
      send_item(bmra_pkg::OP_ALLOC, 10'd0, 32'd0);
      // oversize run length clamps to the maximum and cannot fit 32 free bits
      apply_settings(24'd8191, 24'd4, 24'hFF_FFFF);
      send_item(bmra_pkg::OP_ALLOC, 10'd0, 32'd0);
      // empty map: nothing in use at all
      apply_settings(24'd4096, 24'd0, 24'd0);
      send_item(bmra_pkg::OP_ALLOC, 10'd0, 32'd0);
      send_item(bmra_pkg::OP_READ, 10'd0, 32'd0);

      // Random phases. Smallest map with single-bit runs, then a phase with the long
      // receiver hold, then the oversize map count, then random settings.
      run_phase(1, 1, 24'd0, 22, 1'b0);
      run_phase($urandom_range(1, 40), 8, 24'($urandom), 22, 1'b1);
      run_phase(16, 2047, 24'hFF_FFFF, 22, 1'b0);
      while (items_sent < ITEM_GOAL) begin
         run_phase(pick_run(), ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16),
                   24'($urandom), 22, 1'b0);
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      // a few more cycles to catch any stray reply
      repeat (20) @(posedge clock);
      if (sb.errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
